>>> hdl/shabc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shabc_pkg: SHA-256 block compression shared definitions
// Transfer types, command bundle, initial hash, round constants and the
// SHA-256 bit functions.
// ---------------------------------------------------------------------------
package shabc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned HashN   = 8;
  localparam int unsigned SchedN  = 16;
  localparam int unsigned RoundN  = 64;
  localparam int unsigned WcntW   = 4;
  localparam int unsigned RcntW   = 6;
  localparam int unsigned OidxW   = 3;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic [31:0] msg_word;
    logic        restart;
    logic        last_block;
  } shabc_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } shabc_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             shift_word;  // push the accepted word into the schedule
    logic             reload_iv;   // restart: chaining hash back to the IV
    logic             load_vars;   // copy chaining hash into a..h
    logic             run_round;   // one compression round
    logic [RcntW-1:0] round;       // index of that round
    logic             fold_hash;   // add a..h into the chaining hash
    logic [OidxW-1:0] out_idx;     // digest word to present
  } shabc_cmd_t;

  localparam word_t INIT_HASH [HashN] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [RoundN] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

>>> hdl/sha256_block_compress.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha256_block_compress: SHA-256 block compression
// Takes big-endian packed message words, compresses each 16-word block and
// streams out the eight-word digest after a block flagged as last.
// ---------------------------------------------------------------------------
// The sixteenth word of a block starts the compression: 64 rounds at one round
// per cycle through a single round unit, then a fold that adds a..h into the
// chaining hash, during which the input is stalled. If the sixteenth word
// carried last_block, the eight digest words (H0 first, digest_last on the
// eighth) follow as eight transfers, and the input stays stalled until the
// last of them is taken. restart on a word reloads the standard initial hash
// and makes that word the first of a fresh block, dropping any partial
// block; without it the chain continues from the previous block. last_block
// is looked at only on the sixteenth word of a block. There is no clearing
// pass after reset.
// ---------------------------------------------------------------------------
module sha256_block_compress (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  shabc_pkg::shabc_in_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output shabc_pkg::shabc_out_t  out_data_o
);

  shabc_pkg::shabc_cmd_t cmd;
  shabc_pkg::word_t      digest_word;
  logic                  digest_last;

  // Sequencer: word and round counts, output walk
  shabc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_restart_i (in_data_i.restart),
    .in_last_i    (in_data_i.last_block),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_last_o   (digest_last),
    .cmd_o        (cmd)
  );

  // Schedule, round unit and chaining hash
  shabc_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .msg_word_i    (in_data_i.msg_word),
    .digest_word_o (digest_word)
  );

  // Digest words come straight from the hash registers, which hold still
  // while the output is stalled
  always_comb begin
    out_data_o              = '0;
    out_data_o.digest_word  = digest_word;
    out_data_o.digest_index = cmd.out_idx;
    out_data_o.digest_last  = digest_last;
  end

endmodule

>>> hdl/shabc_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shabc_ctrl: SHA-256 compression sequencer
// Counts message words and rounds, and walks the digest words out.
// ---------------------------------------------------------------------------
module shabc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_restart_i,
  input  logic                  in_last_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  out_last_o,
  output shabc_pkg::shabc_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_FINAL = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  localparam logic [shabc_pkg::WcntW-1:0] WcntLast = shabc_pkg::WcntW'(shabc_pkg::SchedN - 1);
  localparam logic [shabc_pkg::RcntW-1:0] RcntLast = shabc_pkg::RcntW'(shabc_pkg::RoundN - 1);
  localparam logic [shabc_pkg::OidxW-1:0] OidxLast = shabc_pkg::OidxW'(shabc_pkg::HashN - 1);

  state_e                        state_q, state_d;
  logic [shabc_pkg::WcntW-1:0]   wcnt_q, wcnt_d;
  logic [shabc_pkg::RcntW-1:0]   rcnt_q, rcnt_d;
  logic [shabc_pkg::OidxW-1:0]   oidx_q, oidx_d;
  logic                          last_q, last_d;
  logic                          in_xfer;
  logic                          out_xfer;
  logic                          block_full;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign out_last_o  = (oidx_q == OidxLast);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_o && !out_stall_i;
  // the sixteenth word of a block; a restart always starts a fresh block
  assign block_full  = in_xfer && !in_restart_i && (wcnt_q == WcntLast);

  always_comb begin
    state_d = state_q;
    wcnt_d  = wcnt_q;
    rcnt_d  = rcnt_q;
    oidx_d  = oidx_q;
    last_d  = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          wcnt_d = in_restart_i ? shabc_pkg::WcntW'(1) : wcnt_q + shabc_pkg::WcntW'(1);
          last_d = in_last_i;
        end
        if (block_full) begin
          state_d = ST_ROUND;
          rcnt_d  = '0;
        end
      end
      ST_ROUND: begin
        rcnt_d = rcnt_q + shabc_pkg::RcntW'(1);
        if (rcnt_q == RcntLast) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        oidx_d  = '0;
        state_d = last_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_xfer) begin
          oidx_d = oidx_q + shabc_pkg::OidxW'(1);
          if (oidx_q == OidxLast) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wcnt_q  <= '0;
      rcnt_q  <= '0;
      oidx_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wcnt_q  <= wcnt_d;
      rcnt_q  <= rcnt_d;
      oidx_q  <= oidx_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.shift_word = in_xfer;
    cmd_o.reload_iv  = in_xfer && in_restart_i;
    cmd_o.load_vars  = block_full;
    cmd_o.run_round  = (state_q == ST_ROUND);
    cmd_o.round      = rcnt_q;
    cmd_o.fold_hash  = (state_q == ST_FINAL);
    cmd_o.out_idx    = oidx_q;
  end

  // Rounds always start with a complete block behind them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (wcnt_q == '0))
    else $error("round running with a partial block");

  // The first round follows directly on the sixteenth word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && rcnt_q == '0) |-> ($past(state_q) == ST_IDLE))
    else $error("round zero not entered from idle");

  // The fold happens only after all rounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINAL) |-> ($past(state_q) == ST_ROUND && $past(rcnt_q) == RcntLast))
    else $error("hash fold before the last round");

  // The eighth digest transfer ends the output burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && out_last_o) |=> (state_q == ST_IDLE))
    else $error("digest burst did not end after the eighth word");

endmodule

>>> hdl/shabc_dpath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shabc_dpath: SHA-256 round datapath
// Message schedule shift line, working variables a..h and chaining hash.
// ---------------------------------------------------------------------------
module shabc_dpath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  shabc_pkg::shabc_cmd_t cmd_i,
  input  shabc_pkg::word_t      msg_word_i,
  output shabc_pkg::word_t      digest_word_o
);

  shabc_pkg::word_t sched_q [shabc_pkg::SchedN];
  shabc_pkg::word_t sched_d [shabc_pkg::SchedN];
  shabc_pkg::word_t vars_q  [shabc_pkg::HashN];
  shabc_pkg::word_t vars_d  [shabc_pkg::HashN];
  shabc_pkg::word_t hash_q  [shabc_pkg::HashN];
  shabc_pkg::word_t hash_d  [shabc_pkg::HashN];
  shabc_pkg::word_t w_next;
  shabc_pkg::word_t t1;
  shabc_pkg::word_t t2;
  shabc_pkg::word_t ch;
  shabc_pkg::word_t maj;

  // sched_q[0] holds W[t]; W[t+16] enters at the top
  assign w_next = shabc_pkg::small_sigma1(sched_q[14]) + sched_q[9]
                + shabc_pkg::small_sigma0(sched_q[1]) + sched_q[0];

  assign ch  = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
  assign maj = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
  assign t1  = vars_q[7] + shabc_pkg::big_sigma1(vars_q[4]) + ch
             + shabc_pkg::ROUND_K[cmd_i.round] + sched_q[0];
  assign t2  = shabc_pkg::big_sigma0(vars_q[0]) + maj;

  always_comb begin
    for (int i = 0; i < shabc_pkg::SchedN; i++) begin
      sched_d[i] = sched_q[i];
    end
    if (cmd_i.shift_word || cmd_i.run_round) begin
      for (int i = 0; i < shabc_pkg::SchedN - 1; i++) begin
        sched_d[i] = sched_q[i+1];
      end
      sched_d[shabc_pkg::SchedN-1] = cmd_i.shift_word ? msg_word_i : w_next;
    end
  end

  always_comb begin
    for (int i = 0; i < shabc_pkg::HashN; i++) begin
      vars_d[i] = vars_q[i];
    end
    if (cmd_i.load_vars) begin
      for (int i = 0; i < shabc_pkg::HashN; i++) begin
        vars_d[i] = hash_q[i];
      end
    end else if (cmd_i.run_round) begin
      vars_d[7] = vars_q[6];
      vars_d[6] = vars_q[5];
      vars_d[5] = vars_q[4];
      vars_d[4] = vars_q[3] + t1;
      vars_d[3] = vars_q[2];
      vars_d[2] = vars_q[1];
      vars_d[1] = vars_q[0];
      vars_d[0] = t1 + t2;
    end
  end

  always_comb begin
    for (int i = 0; i < shabc_pkg::HashN; i++) begin
      if (cmd_i.reload_iv) begin
        hash_d[i] = shabc_pkg::INIT_HASH[i];
      end else if (cmd_i.fold_hash) begin
        hash_d[i] = hash_q[i] + vars_q[i];
      end else begin
        hash_d[i] = hash_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < shabc_pkg::SchedN; i++) begin
      sched_q[i] <= sched_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < shabc_pkg::HashN; i++) begin
        hash_q[i] <= shabc_pkg::INIT_HASH[i];
        vars_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < shabc_pkg::HashN; i++) begin
        hash_q[i] <= hash_d[i];
        vars_q[i] <= vars_d[i];
      end
    end
  end

  assign digest_word_o = hash_q[cmd_i.out_idx];

endmodule
